@@ sv/pfdrc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfdrc_pkg
// Shared types, request codes and helpers for the packet FIFO with duplicate
// filter and range count.
// ----------------------------------------------------------------------------
package pfdrc_pkg;

	localparam int unsigned SRC_W      = 16;
	localparam int unsigned DST_W      = 16;
	localparam int unsigned STAMP_W    = 32;
	localparam int unsigned LIMIT_W    = 7;
	localparam int unsigned COUNT_W    = 7;
	localparam int unsigned REQ_W      = 2;
	localparam int unsigned IN_DATA_W  = 128;
	localparam int unsigned OUT_DATA_W = 80;
	localparam int unsigned TALLY_GRP  = 8;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD   = 2'd0,
		REQ_FWD   = 2'd1,
		REQ_COUNT = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef struct packed {
		logic [SRC_W-1:0]   src;
		logic [DST_W-1:0]   dst;
		logic [STAMP_W-1:0] stamp;
	} pkt_t;

	typedef struct packed {
		pkt_t               pkt;
		logic [STAMP_W-1:0] lo;
		logic [STAMP_W-1:0] hi;
	} qry_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	function automatic logic [3:0] pop8(input logic [TALLY_GRP-1:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < TALLY_GRP; i++) begin
			n = n + {3'd0, v[i]};
		end
		return n;
	endfunction

endpackage

@@ sv/packet_fifo_dedup_range_count_unit.sv @@
// ----------------------------------------------------------------------------
// packet_fifo_dedup_range_count_unit
// Bounded packet FIFO with duplicate rejection, oldest-drop on overflow,
// forward of the oldest packet and a destination and time range count.
//
// Channel  | Dir | Contents (low bits first)
// s_axis   | in  | tuser: req_type; tdata: src_id, dst_id, stamp, range_start,
//          |     | range_end
// m_axis   | out | tdata: added, pkt_valid, out_src, out_dst, out_stamp,
//          |     | match_count, zero fill
// cfg      | in  | cfg_we, cfg_wdata: mem_limit
//
// Each request passes the capture state, where the tally registers the slot
// flags, and the sweep state, where the tally walks them eight at a time; the
// result is then registered. A new request is accepted once the previous result
// sits in the output register, so a request is finished before the next one is
// taken. Reset empties the queue and sets the limit to 64. A stalled result
// holds the block in its sweep state until the output is taken.
// ----------------------------------------------------------------------------
module packet_fifo_dedup_range_count_unit #(
	parameter int unsigned DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [pfdrc_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // src_id, dst_id, stamp,
	                                                          // range_start, range_end
	input  logic [1:0]   s_axis_tuser,   // req_type
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [pfdrc_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // added, pkt_valid, out_src,
	                                                          // out_dst, out_stamp,
	                                                          // match_count, zero fill
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata
);
	import pfdrc_pkg::*;

	localparam int unsigned OW  = $clog2(DEPTH + 1);
	localparam int unsigned LW  = (OW > LIMIT_W) ? OW : LIMIT_W;
	localparam int unsigned CW  = (OW > COUNT_W) ? OW : COUNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CAPT,
		ST_SWEEP
	} state_t;

	state_t               state_q;
	logic                 m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [OW-1:0]        occ_q;
	logic [LIMIT_W-1:0]   limit_q;
	req_t                 req_q;
	qry_t                 qry_q;

	pkt_t                 ent [DEPTH];
	logic [DEPTH-1:0]     eq;
	logic [DEPTH-1:0]     hit;
	cell_ctl_t            ctl;
	logic [OW-1:0]        wr_pos;
	logic                 busy;
	logic                 dup;
	logic [CW-1:0]        cnt;
	logic [LW-1:0]        lim;
	logic                 evict;
	logic                 finish;
	logic                 in_take;
	logic [OUT_DATA_W-1:0] res;
	logic [OW-1:0]        occ_nx;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign finish        = (state_q == ST_SWEEP) && !busy && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q      <= req_t'(s_axis_tuser);
			qry_q.pkt.src   <= s_axis_tdata[15:0];
			qry_q.pkt.dst   <= s_axis_tdata[31:16];
			qry_q.pkt.stamp <= s_axis_tdata[63:32];
			qry_q.lo   <= s_axis_tdata[95:64];
			qry_q.hi   <= s_axis_tdata[127:96];
		end
	end

	always_comb begin
		if (limit_q == '0) begin
			lim = LW'(1);
		end else if (LW'(limit_q) > LW'(DEPTH)) begin
			lim = LW'(DEPTH);
		end else begin
			lim = LW'(limit_q);
		end
	end

	assign evict = LW'(occ_q) >= lim;

	always_comb begin
		ctl    = '0;
		wr_pos = occ_q;
		occ_nx = occ_q;
		res    = '0;
		unique case (req_q)
			REQ_ADD: begin
				if (!dup) begin
					ctl.load  = 1'b1;
					ctl.shift = evict;
					res[0]    = 1'b1;
					if (evict) begin
						wr_pos = occ_q - 1'b1;
					end else begin
						occ_nx = occ_q + 1'b1;
					end
				end
			end
			REQ_FWD: begin
				if (occ_q != '0) begin
					ctl.shift  = 1'b1;
					occ_nx     = occ_q - 1'b1;
					res[1]     = 1'b1;
					res[17:2]  = ent[0].src;
					res[33:18] = ent[0].dst;
					res[65:34] = ent[0].stamp;
				end
			end
			REQ_COUNT: begin
				res[72:66] = cnt[COUNT_W-1:0];
			end
			default: begin
				res = '0;
			end
		endcase
		if (!finish) begin
			ctl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			occ_q     <= '0;
		end else begin
			if (finish) begin
				m_valid_q <= 1'b1;
				m_data_q  <= res;
				occ_q     <= occ_nx;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_CAPT;
					end
				end
				ST_CAPT: begin
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		pkt_t nbr;
		if (i == DEPTH - 1) begin : g_tail
			assign nbr = qry_q.pkt;
		end else begin : g_body
			assign nbr = ent[i+1];
		end
		pfdrc_cell #(
			.IDX (i),
			.OW  (OW)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.wr_pos (wr_pos),
			.din    (qry_q.pkt),
			.nbr    (nbr),
			.qry    (qry_q),
			.occ    (occ_q),
			.ent    (ent[i]),
			.eq     (eq[i]),
			.hit    (hit[i])
		);
	end

	pfdrc_tally #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_tally (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_CAPT),
		.eq     (eq),
		.hit    (hit),
		.busy   (busy),
		.dup    (dup),
		.cnt    (cnt)
	);

endmodule

@@ sv/pfdrc_cell.sv @@
// ----------------------------------------------------------------------------
// pfdrc_cell
// One packet slot of the queue. Takes its neighbor's packet on a pop, loads a
// new packet at its position, and compares itself against the current query.
// ----------------------------------------------------------------------------
module pfdrc_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned OW  = 7
) (
	input  logic               clk,
	input  pfdrc_pkg::cell_ctl_t ctl,
	input  logic [OW-1:0]      wr_pos,
	input  pfdrc_pkg::pkt_t    din,
	input  pfdrc_pkg::pkt_t    nbr,
	input  pfdrc_pkg::qry_t    qry,
	input  logic [OW-1:0]      occ,
	output pfdrc_pkg::pkt_t    ent,
	output logic               eq,
	output logic               hit
);
	import pfdrc_pkg::*;

	pkt_t ent_q;
	logic here;
	logic used;

	assign here = ctl.load && (wr_pos == OW'(IDX));
	assign used = OW'(IDX) < occ;

	always_ff @(posedge clk) begin
		if (here) begin
			ent_q <= din;
		end else if (ctl.shift) begin
			ent_q <= nbr;
		end
	end

	assign ent = ent_q;
	assign eq  = used && (ent_q == qry.pkt);
	assign hit = used && (ent_q.dst == qry.pkt.dst) &&
		(ent_q.stamp >= qry.lo) && (ent_q.stamp <= qry.hi);

endmodule

@@ sv/pfdrc_tally.sv @@
// ----------------------------------------------------------------------------
// pfdrc_tally
// Captures the per-slot match flags and walks them in groups of eight,
// collecting the duplicate flag and the count of range hits.
// ----------------------------------------------------------------------------
module pfdrc_tally #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned CW    = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEPTH-1:0] eq,
	input  logic [DEPTH-1:0] hit,
	output logic             busy,
	output logic             dup,
	output logic [CW-1:0]    cnt
);
	import pfdrc_pkg::*;

	localparam int unsigned NG = (DEPTH + TALLY_GRP - 1) / TALLY_GRP;
	localparam int unsigned PW = NG * TALLY_GRP;
	localparam int unsigned GW = (NG > 1) ? $clog2(NG) : 1;

	logic [PW-1:0] eq_q;
	logic [PW-1:0] hit_q;
	logic [GW-1:0] grp_q;
	logic          run_q;
	logic          dup_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			grp_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			grp_q <= '0;
		end else if (run_q) begin
			if (grp_q == GW'(NG - 1)) begin
				run_q <= 1'b0;
			end
			grp_q <= grp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			eq_q  <= PW'(eq);
			hit_q <= PW'(hit);
			dup_q <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			eq_q  <= eq_q >> TALLY_GRP;
			hit_q <= hit_q >> TALLY_GRP;
			dup_q <= dup_q | (|eq_q[TALLY_GRP-1:0]);
			cnt_q <= cnt_q + CW'(pop8(hit_q[TALLY_GRP-1:0]));
		end
	end

	assign busy = run_q;
	assign dup  = dup_q;
	assign cnt  = cnt_q;

endmodule
